[src/vmt_pkg.sv]
`timescale 1ns / 1ps
package vmt_pkg;

  // Operation codes carried on the mode field of a request.
  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;

  localparam int MODE_W      = 2;
  localparam int IN_VALUE_W  = 32;
  localparam int OUT_COUNT_W = 5;

  typedef logic [MODE_W-1:0] mode_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture the request payload
    logic compare;  // compare every stored entry against the captured value
    logic update;   // apply the operation and register the result
  } vmt_cmd_t;

endpackage

[src/value_multiset_table_unit.sv]
`timescale 1ns / 1ps
// Ordered multiset table of up to CAPACITY values. A request is taken when
// start is high and busy is low; it adds a value at the end of the list
// (refused with dropped set when the list is full), removes the first equal
// entry and closes the gap, or only checks membership. Each request goes
// through capture, a compare of the value against all stored entries at
// once, and an update that applies the change; the controller takes no new
// request while busy is high during compare and update. The result is
// shown for exactly one cycle with out_valid high, the cycle after the update,
// and the receiver cannot stall it, so it must take every result as it comes.
// Busy is already low in that cycle, so the next request may be taken then.
// Entries that were never written have no reset value; only occupied entries
// are ever compared or reported on, so no clearing pass is needed.
module value_multiset_table_unit #(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  vmt_pkg::mode_t                   in_mode,
  input  logic [vmt_pkg::IN_VALUE_W-1:0]   in_value,
  output logic                             out_valid,
  output logic                             out_found,
  output logic [vmt_pkg::OUT_COUNT_W-1:0]  out_count,
  output logic                             out_empty_res,
  output logic                             out_dropped
);
  import vmt_pkg::*;

  // Command bundle from the controller to the datapath.
  vmt_cmd_t cmd;

  // The controller steps through capture, compare and update for each
  // request and holds busy high until the update is done.
  vmt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // The datapath holds the entries, the fill count and the result registers.
  vmt_datapath #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_mode       (in_mode),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_found     (out_found),
    .out_count     (out_count),
    .out_empty_res (out_empty_res),
    .out_dropped   (out_dropped)
  );

endmodule

[src/vmt_ctrl.sv]
`timescale 1ns / 1ps
module vmt_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  output vmt_pkg::vmt_cmd_t cmd
);
  import vmt_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd.load    = 1'b0;
    cmd.compare = 1'b0;
    cmd.update  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd.compare = 1'b1;
        state_nxt   = ST_UPD;
      end
      ST_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

[src/vmt_datapath.sv]
`timescale 1ns / 1ps
module vmt_datapath #(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  vmt_pkg::vmt_cmd_t                   cmd,
  input  vmt_pkg::mode_t                      in_mode,
  input  logic [vmt_pkg::IN_VALUE_W-1:0]      in_value,
  output logic                                out_valid,
  output logic                                out_found,
  output logic [vmt_pkg::OUT_COUNT_W-1:0]     out_count,
  output logic                                out_empty_res,
  output logic                                out_dropped
);
  import vmt_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic [VALUE_WIDTH-1:0] value_in;
  mode_t                  mode_r;
  logic [VALUE_WIDTH-1:0] value_r;
  logic [VALUE_WIDTH-1:0] entries_r   [CAPACITY];
  logic [VALUE_WIDTH-1:0] entries_nxt [CAPACITY];
  logic [CW-1:0]          count_r;
  logic [CW-1:0]          count_nxt;
  logic [CAPACITY-1:0]    match_r;
  logic [CAPACITY-1:0]    match_nxt;
  logic [CAPACITY-2:0]    shift_en;
  logic                   found;
  logic                   full;
  logic                   dropped;
  logic                   out_valid_r;
  logic                   out_found_r;
  logic [CW-1:0]          out_count_r;
  logic                   out_empty_r;
  logic                   out_dropped_r;

  // Only the low VALUE_WIDTH bits of the request value take part.
  if (VALUE_WIDTH <= IN_VALUE_W) begin : g_val_narrow
    assign value_in = in_value[VALUE_WIDTH-1:0];
  end else begin : g_val_wide
    assign value_in = {{(VALUE_WIDTH - IN_VALUE_W){1'b0}}, in_value};
  end

  // Every occupied entry is compared side by side.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match_nxt[i] = (entries_r[i] == value_r) && (CW'(i) < count_r);
    end
  end

  // An entry moves down when the first match sits at or below it.
  always_comb begin
    for (int i = 0; i < CAPACITY - 1; i++) begin
      shift_en[i] = |(match_r & ({CAPACITY{1'b1}} >> (CAPACITY - 1 - i)));
    end
  end

  assign found   = |match_r;
  assign full    = (count_r == CW'(CAPACITY));
  assign dropped = (mode_r == MODE_ADD) && full;

  always_comb begin
    count_nxt = count_r;
    for (int i = 0; i < CAPACITY; i++) begin
      entries_nxt[i] = entries_r[i];
    end
    unique case (mode_r)
      MODE_ADD: begin
        if (!full) begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (count_r == CW'(i)) begin
              entries_nxt[i] = value_r;
            end
          end
          count_nxt = count_r + CW'(1);
        end
      end
      MODE_REMOVE: begin
        if (found) begin
          for (int i = 0; i < CAPACITY - 1; i++) begin
            if (shift_en[i]) begin
              entries_nxt[i] = entries_r[i + 1];
            end
          end
          count_nxt = count_r - CW'(1);
        end
      end
      default: begin
        // Query, and the unused code, leave the list alone.
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= in_mode;
      value_r <= value_in;
    end
    if (cmd.compare) begin
      match_r <= match_nxt;
    end
    if (cmd.update) begin
      for (int i = 0; i < CAPACITY; i++) begin
        entries_r[i] <= entries_nxt[i];
      end
      out_found_r   <= found;
      out_count_r   <= count_nxt;
      out_empty_r   <= (count_nxt == '0);
      out_dropped_r <= dropped;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.update;
      if (cmd.update) begin
        count_r <= count_nxt;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_found     = out_found_r;
  assign out_empty_res = out_empty_r;
  assign out_dropped   = out_dropped_r;

  if (CW >= OUT_COUNT_W) begin : g_cnt_trunc
    assign out_count = out_count_r[OUT_COUNT_W-1:0];
  end else begin : g_cnt_ext
    assign out_count = {{(OUT_COUNT_W - CW){1'b0}}, out_count_r};
  end

endmodule
